// ===== rtl/core/histogram_range_colorizer_assert.svh =====
// Assertion macros shared by the histogram range colorizer RTL.
// Included by modules that carry concurrent checks; depends on nothing else.
`ifndef HISTOGRAM_RANGE_COLORIZER_ASSERT_SVH
`define HISTOGRAM_RANGE_COLORIZER_ASSERT_SVH
`ifndef SYNTHESIS
// Check that is switched off while the reset is high.
`define HRC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that holds at every edge, reset included.
`define HRC_ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HRC_ASSERT(lbl, clk, rst, prop, msg)
`define HRC_ASSERT_ANY(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/hrc_pkg.sv =====
// Package of the histogram range colorizer: field widths, register codes,
// reset values, controller states and the range lookup. Depends on nothing.
`default_nettype none

package hrc_pkg;

  localparam int MAX_ITERATIONS_DEF = 1024;
  localparam int COUNT_WIDTH_DEF    = 20;
  localparam int NUM_RANGES_DEF     = 3;

  localparam int ITER_W     = 11;
  localparam int BOUND_W    = 11;
  localparam int COLOR_W    = 24;
  localparam int CH_W       = 8;
  localparam int NUM_BOUNDS = 4;
  localparam int RANGE_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  typedef logic [NUM_BOUNDS-1:0][BOUND_W-1:0] bound_arr_t;
  typedef logic [NUM_BOUNDS-1:0][COLOR_W-1:0] color_arr_t;

  localparam bound_arr_t BOUND_RST = {11'd1024, 11'd512, 11'd307, 11'd0};
  localparam color_arr_t COLOR_RST = {24'hFFFFFF, 24'hFFFF00, 24'hFF0000, 24'h000000};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOUND_0 = 3'd0,
    CFG_BOUND_1 = 3'd1,
    CFG_BOUND_2 = 3'd2,
    CFG_BOUND_3 = 3'd3,
    CFG_COLOR_0 = 3'd4,
    CFG_COLOR_1 = 3'd5,
    CFG_COLOR_2 = 3'd6,
    CFG_COLOR_3 = 3'd7
  } cfg_reg_t;

  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_COLOR = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_WALK,
    ST_DRAIN,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;       // capture the input beat
    logic clr;        // write zero at the sweep address
    logic cnt_rd;     // read the bin of the captured count
    logic cnt_wr;     // write back the bin, bump the range total
    logic walk_init;  // load the walk address from the range's lower bound
    logic walk_rd;    // read one bin of the walk
    logic mul;        // form the numerators, start the dividers
    logic div_step;   // one quotient bit in every lane
    logic out_load;   // move the color into the output register
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_color;
    logic over_max;
    logic walk_empty;
    logic walk_last;
    logic div_done;
    logic out_free;
  } sts_t;

  // Smallest i in 1..num_ranges whose bound lies above the count, minus one.
  function automatic logic [RANGE_W-1:0] find_range(input logic [ITER_W-1:0] it,
                                                    input bound_arr_t bounds,
                                                    input int num_ranges);
    logic [RANGE_W-1:0] r;
    r = RANGE_W'(num_ranges - 1);
    for (int i = NUM_BOUNDS - 1; i >= 1; i--) begin
      if (i <= num_ranges && bounds[i] > it) begin
        r = RANGE_W'(i - 1);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hrc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; used for the histogram bins.
`default_nettype none

module hrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hrc_ctrl.sv =====
// Controller of the histogram range colorizer: sequences the clear sweep,
// counting, bin walk, division and output. Depends on hrc_pkg.
`default_nettype none

module hrc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  input  wire hrc_pkg::sts_t sts,
  output logic               in_ready,
  output hrc_pkg::cmd_t      cmd
);

  hrc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hrc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      hrc_pkg::ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = hrc_pkg::ST_IDLE;
        end
      end
      hrc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = s_tvalid;
        if (s_tvalid) begin
          state_next = hrc_pkg::ST_DECIDE;
        end
      end
      hrc_pkg::ST_DECIDE: begin
        priority if (!sts.is_color && sts.over_max) begin
          state_next = hrc_pkg::ST_IDLE;
        end else if (!sts.is_color) begin
          state_next = hrc_pkg::ST_CNT_RD;
        end else if (sts.over_max) begin
          state_next = hrc_pkg::ST_OUT;
        end else if (sts.walk_empty) begin
          state_next = hrc_pkg::ST_MUL;
        end else begin
          cmd.walk_init = 1'b1;
          state_next    = hrc_pkg::ST_WALK;
        end
      end
      hrc_pkg::ST_CNT_RD: begin
        cmd.cnt_rd = 1'b1;
        state_next = hrc_pkg::ST_CNT_WR;
      end
      hrc_pkg::ST_CNT_WR: begin
        cmd.cnt_wr = 1'b1;
        state_next = hrc_pkg::ST_IDLE;
      end
      hrc_pkg::ST_WALK: begin
        cmd.walk_rd = 1'b1;
        if (sts.walk_last) begin
          state_next = hrc_pkg::ST_DRAIN;
        end
      end
      hrc_pkg::ST_DRAIN: begin
        state_next = hrc_pkg::ST_MUL;
      end
      hrc_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = hrc_pkg::ST_DIV;
      end
      hrc_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_next = hrc_pkg::ST_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      hrc_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = hrc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hrc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/hrc_datapath.sv =====
// Datapath of the histogram range colorizer: configuration registers, bin RAM,
// range totals, walk accumulator, three divider lanes and the output register.
// Depends on hrc_pkg, hrc_ram and histogram_range_colorizer_assert.svh.
`default_nettype none
`include "histogram_range_colorizer_assert.svh"

module hrc_datapath #(
  parameter int MAX_ITERATIONS = hrc_pkg::MAX_ITERATIONS_DEF,
  parameter int COUNT_WIDTH    = hrc_pkg::COUNT_WIDTH_DEF,
  parameter int NUM_RANGES     = hrc_pkg::NUM_RANGES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire hrc_pkg::cmd_t                   cmd,
  output hrc_pkg::sts_t                        sts,
  input  wire logic [hrc_pkg::IN_DATA_W-1:0]   s_tdata,
  input  wire logic                            s_tuser,
  input  wire logic                            cfg_we,
  input  wire logic [hrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hrc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            m_tready,
  output logic                                 m_tvalid,
  output logic      [hrc_pkg::OUT_DATA_W-1:0]  m_tdata
);

  localparam int AW    = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;
  localparam int SUMW  = COUNT_WIDTH + AW;
  localparam int NUMW  = hrc_pkg::CH_W + SUMW;
  localparam int DCW   = $clog2(NUMW + 1);
  localparam int CH_W  = hrc_pkg::CH_W;
  localparam int LANES = 3;
  localparam logic [31:0] MaxIt = 32'(MAX_ITERATIONS);
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  // Configuration registers.
  hrc_pkg::bound_arr_t bounds;
  hrc_pkg::color_arr_t colors;

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds <= hrc_pkg::BOUND_RST;
      colors <= hrc_pkg::COLOR_RST;
    end else if (cfg_we) begin
      unique case (hrc_pkg::cfg_reg_t'(cfg_index))
        hrc_pkg::CFG_BOUND_0: bounds[0] <= cfg_data[hrc_pkg::BOUND_W-1:0];
        hrc_pkg::CFG_BOUND_1: bounds[1] <= cfg_data[hrc_pkg::BOUND_W-1:0];
        hrc_pkg::CFG_BOUND_2: bounds[2] <= cfg_data[hrc_pkg::BOUND_W-1:0];
        hrc_pkg::CFG_BOUND_3: bounds[3] <= cfg_data[hrc_pkg::BOUND_W-1:0];
        hrc_pkg::CFG_COLOR_0: colors[0] <= cfg_data[hrc_pkg::COLOR_W-1:0];
        hrc_pkg::CFG_COLOR_1: colors[1] <= cfg_data[hrc_pkg::COLOR_W-1:0];
        hrc_pkg::CFG_COLOR_2: colors[2] <= cfg_data[hrc_pkg::COLOR_W-1:0];
        hrc_pkg::CFG_COLOR_3: colors[3] <= cfg_data[hrc_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured item and its range.
  logic                          kind_q;
  logic [hrc_pkg::ITER_W-1:0]    it_q;
  logic [hrc_pkg::RANGE_W-1:0]   r_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= s_tuser;
      it_q   <= s_tdata[hrc_pkg::ITER_W-1:0];
      r_q    <= hrc_pkg::find_range(s_tdata[hrc_pkg::ITER_W-1:0], bounds, NUM_RANGES);
    end
  end

  logic                         over_max;
  logic [AW-1:0]                it_addr;
  logic [hrc_pkg::BOUND_W-1:0]  bound_lo;

  assign over_max = 32'(it_q) >= MaxIt;
  assign it_addr  = AW'(it_q);
  assign bound_lo = bounds[r_q];

  // Shared address counter: clear sweep after reset, then the bin walk.
  logic [AW-1:0] addr_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_q <= '0;
    end else if (cmd.walk_init) begin
      addr_q <= AW'(bound_lo);
    end else if (cmd.clr || cmd.walk_rd) begin
      addr_q <= addr_q + AW'(1);
    end
  end

  // Histogram bins.
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic [COUNT_WIDTH-1:0] bin_inc;

  assign bin_inc   = (ram_rdata == CountMax) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);
  assign ram_we    = cmd.clr || cmd.cnt_wr;
  assign ram_waddr = cmd.clr ? addr_q : it_addr;
  assign ram_wdata = cmd.clr ? '0 : bin_inc;

  hrc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (MAX_ITERATIONS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.cnt_rd || cmd.walk_rd),
    .raddr (cmd.walk_rd ? addr_q : it_addr),
    .rdata (ram_rdata)
  );

  // Walk accumulator; read data lands in the cycle after the read.
  logic            rd_pend;
  logic [SUMW-1:0] sum_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.walk_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum_q <= '0;
    end else if (rd_pend) begin
      sum_q <= sum_q + SUMW'(ram_rdata);
    end
  end

  // Range totals.
  logic [COUNT_WIDTH-1:0] totals [NUM_RANGES];
  logic [COUNT_WIDTH-1:0] tot_sel;

  always_comb begin
    tot_sel = '0;
    for (int j = 0; j < NUM_RANGES; j++) begin
      if (r_q == hrc_pkg::RANGE_W'(j)) begin
        tot_sel = totals[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NUM_RANGES; j++) begin
        totals[j] <= '0;
      end
    end else if (cmd.cnt_wr) begin
      for (int j = 0; j < NUM_RANGES; j++) begin
        if (r_q == hrc_pkg::RANGE_W'(j) && totals[j] != CountMax) begin
          totals[j] <= totals[j] + COUNT_WIDTH'(1);
        end
      end
    end
  end

  // Divider control.
  logic [COUNT_WIDTH-1:0] total_q;
  logic [DCW-1:0]         div_cnt;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      total_q <= tot_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.mul) begin
      div_cnt <= DCW'(NUMW);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - DCW'(1);
    end
  end

  logic [hrc_pkg::COLOR_W-1:0] color_lo;
  logic [hrc_pkg::COLOR_W-1:0] color_hi;
  logic                        black;

  assign color_lo = colors[r_q];
  assign color_hi = colors[r_q + hrc_pkg::RANGE_W'(1)];
  assign black    = (kind_q == hrc_pkg::KIND_COLOR) && over_max;

  // Lanes: red, green, blue. Each forms |diff| * sum, then divides it by
  // the range total one quotient bit a cycle, restoring style.
  logic [NUMW-1:0]        num_q [LANES];
  logic [COUNT_WIDTH-1:0] rem_q [LANES];
  logic                   neg_q [LANES];
  logic [CH_W-1:0]        chan  [LANES];

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    localparam int Sh = 16 - 8 * k;

    logic [CH_W-1:0]        start_c;
    logic [CH_W-1:0]        end_c;
    logic [CH_W-1:0]        mag;
    logic [COUNT_WIDTH:0]   rem_sh;
    logic                   qbit;
    logic [NUMW:0]          up_sum;
    logic [NUMW:0]          down_q;

    assign start_c = color_lo[Sh +: CH_W];
    assign end_c   = color_hi[Sh +: CH_W];
    assign mag     = (end_c < start_c) ? start_c - end_c : end_c - start_c;
    assign rem_sh  = {rem_q[k], num_q[k][NUMW-1]};
    assign qbit    = rem_sh >= {1'b0, total_q};

    always_ff @(posedge clk) begin
      if (cmd.mul) begin
        num_q[k] <= NUMW'(mag) * NUMW'(sum_q);
        rem_q[k] <= '0;
        neg_q[k] <= end_c < start_c;
      end else if (cmd.div_step) begin
        num_q[k] <= {num_q[k][NUMW-2:0], qbit};
        rem_q[k] <= qbit ? COUNT_WIDTH'(rem_sh - {1'b0, total_q}) : COUNT_WIDTH'(rem_sh);
      end
    end

    // Floor of a negative quotient rounds away from zero; clamp to 0..255.
    assign up_sum = (NUMW + 1)'(start_c) + (NUMW + 1)'(num_q[k]);
    assign down_q = (NUMW + 1)'(num_q[k]) + (NUMW + 1)'(rem_q[k] != '0);

    always_comb begin
      priority if (black) begin
        chan[k] = '0;
      end else if (total_q == '0) begin
        chan[k] = start_c;
      end else if (!neg_q[k]) begin
        chan[k] = (up_sum > (NUMW + 1)'(255)) ? CH_W'(255) : up_sum[CH_W-1:0];
      end else begin
        chan[k] = (down_q > (NUMW + 1)'(start_c)) ? '0 : start_c - down_q[CH_W-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {chan[2], chan[1], chan[0]};
    end
  end

  assign sts.clr_last   = addr_q == AW'(MAX_ITERATIONS - 1);
  assign sts.is_color   = kind_q == hrc_pkg::KIND_COLOR;
  assign sts.over_max   = over_max;
  assign sts.walk_empty = bound_lo > it_q;
  assign sts.walk_last  = addr_q == it_addr;
  assign sts.div_done   = div_cnt == '0;
  assign sts.out_free   = !m_tvalid || m_tready;

  `HRC_ASSERT(a_rem_below_total, clk, rst, (div_cnt != '0 && total_q != '0) |-> rem_q[0] < total_q, "divider remainder reached the divisor")
  `HRC_ASSERT(a_walk_in_range, clk, rst, cmd.walk_rd |-> addr_q <= it_addr, "bin walk passed the requested count")
  `HRC_ASSERT(a_out_no_overwrite, clk, rst, cmd.out_load |-> (!m_tvalid || m_tready), "color loaded over a pending output beat")
  `HRC_ASSERT(a_total_monotonic, clk, rst, !$past(rst) |-> totals[0] >= $past(totals[0]), "range total decreased")

endmodule

`default_nettype wire

// ===== rtl/core/histogram_range_colorizer.sv =====
// Top level of the histogram range colorizer: joins controller and datapath.
// Depends on hrc_pkg, hrc_ctrl, hrc_datapath and hrc_ram.
//
// Usage. Input beats arrive on s_tvalid/s_tready with the item kind on s_tuser
// and the iteration count in s_tdata. A count beat (kind 0) adds one to the
// count's histogram bin and to its color range total, both saturating; counts
// at or above the maximum are ignored. A color beat (kind 1) returns one beat
// on the m_ side with the pixel's red, green and blue channels.
// Timing. One item is worked on at a time. A count beat passes through the
// decide, bin read and bin write-back states before the next ready. A color
// beat walks the bins from the range's lower bound up to its count (none if
// the bound lies above the count), one RAM read per cycle, then runs three
// restoring dividers in parallel, one quotient bit per cycle. The bin RAM's
// single read port sets the walk length. A color beat whose count is at or
// above the maximum skips the walk and the dividers and answers black.
// Reset. After reset a sweep clears all MAX_ITERATIONS bins; s_tready stays
// low meanwhile, while configuration writes are taken at once.
// Stalls. The result waits in an output register, so the block takes the next
// beat while m_tready is low; only a second finished color waits for it.
`default_nettype none

module histogram_range_colorizer #(
  parameter int MAX_ITERATIONS = hrc_pkg::MAX_ITERATIONS_DEF,
  parameter int COUNT_WIDTH    = hrc_pkg::COUNT_WIDTH_DEF,
  parameter int NUM_RANGES     = hrc_pkg::NUM_RANGES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input beats.
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [hrc_pkg::IN_DATA_W-1:0]   s_tdata,  // iterations[10:0], zero pad
  input  wire logic                            s_tuser,  // kind
  // Result beats.
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [hrc_pkg::OUT_DATA_W-1:0]  m_tdata,  // red[7:0], green[15:8], blue[23:16]
  // Configuration writes.
  input  wire logic                            cfg_we,
  input  wire logic [hrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hrc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  hrc_pkg::cmd_t cmd;
  hrc_pkg::sts_t sts;

  // The controller owns sequencing and the input handshake.
  hrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .sts      (sts),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  // The datapath holds all storage, arithmetic and the output register.
  hrc_datapath #(
    .MAX_ITERATIONS (MAX_ITERATIONS),
    .COUNT_WIDTH    (COUNT_WIDTH),
    .NUM_RANGES     (NUM_RANGES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

// ===== test/histogram_range_colorizer_checker.sv =====
// Checker for the histogram range colorizer: follows every accepted beat and
// register write, predicts each pixel color and compares the result beats.
// Depends on hrc_pkg for widths, register codes, item kinds and reset values.
module histogram_range_colorizer_checker
  import hrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    failures,
  output int                    pending,
  output int                    counts_taken,
  output int                    colors_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BINS   = MAX_ITERATIONS_DEF;
  localparam int CW     = COUNT_WIDTH_DEF;
  localparam int RANGES = NUM_RANGES_DEF;
  localparam logic [CW-1:0] COUNT_TOP = '1;

  // Red sits in the low byte of the result beat, so it is the last member.
  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  logic [CW-1:0]      bin_hist    [BINS];
  logic [CW-1:0]      range_total [RANGES];
  logic [BOUND_W-1:0] bnd         [NUM_BOUNDS];
  logic [COLOR_W-1:0] col         [NUM_BOUNDS];
  pixel_t             expected_colors [$];

  // Range of a count: one below the first upper bound, by index, that lies above it.
  function automatic int range_of(int it);
    int r;
    r = RANGES - 1;
    for (int i = RANGES; i >= 1; i--) begin
      if (bnd[i] > it) begin
        r = i - 1;
      end
    end
    return r;
  endfunction

  // Start plus the floored share of the channel step, clamped to a byte.
  function automatic logic [CH_W-1:0] blend_channel(int from_c, int to_c,
                                                    longint part, longint whole);
    longint num, q, v;
    v = from_c;
    if (whole > 0) begin
      num = longint'(to_c - from_c) * part;
      q = num / whole;
      if ((num % whole) != 0 && num < 0) begin
        q = q - 1;
      end
      v = from_c + q;
    end
    if (v < 0) begin
      v = 0;
    end
    if (v > 255) begin
      v = 255;
    end
    return v[CH_W-1:0];
  endfunction

  function automatic pixel_t pixel_color(int it);
    pixel_t p;
    int r;
    longint part;
    p = '0;
    if (it >= BINS) begin
      return p;
    end
    r = range_of(it);
    part = 0;
    for (int i = bnd[r]; i <= it; i++) begin
      part += bin_hist[i];
    end
    p.red   = blend_channel(col[r][16 +: 8], col[r+1][16 +: 8], part, range_total[r]);
    p.green = blend_channel(col[r][8 +: 8],  col[r+1][8 +: 8],  part, range_total[r]);
    p.blue  = blend_channel(col[r][0 +: 8],  col[r+1][0 +: 8],  part, range_total[r]);
    return p;
  endfunction

  function automatic void count_pixel(int it);
    int r;
    if (it >= BINS) begin
      return;
    end
    if (bin_hist[it] != COUNT_TOP) begin
      bin_hist[it]++;
    end
    r = range_of(it);
    if (range_total[r] != COUNT_TOP) begin
      range_total[r]++;
    end
  endfunction

  always @(posedge clk) begin : watch
    pixel_t got, want;
    if (rst) begin
      for (int i = 0; i < BINS; i++) begin
        bin_hist[i] = '0;
      end
      for (int i = 0; i < RANGES; i++) begin
        range_total[i] = '0;
      end
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        bnd[i] = BOUND_RST[i];
        col[i] = COLOR_RST[i];
      end
      expected_colors.delete();
      failures = 0;
      counts_taken = 0;
      colors_checked = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index < CFG_COLOR_0) begin
          bnd[cfg_index - CFG_BOUND_0] = cfg_data[BOUND_W-1:0];
        end else begin
          col[cfg_index - CFG_COLOR_0] = cfg_data[COLOR_W-1:0];
        end
      end
      // Results first: a beat leaving now belongs to an earlier request.
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_colors.size() == 0) begin
          $error("color beat %06h arrived with no color request outstanding", got);
          failures++;
        end else begin
          want = expected_colors.pop_front();
          colors_checked++;
          if (got.red !== want.red) begin
            $error("red mismatch: expected %0d, got %0d", want.red, got.red);
            failures++;
          end
          if (got.green !== want.green) begin
            $error("green mismatch: expected %0d, got %0d", want.green, got.green);
            failures++;
          end
          if (got.blue !== want.blue) begin
            $error("blue mismatch: expected %0d, got %0d", want.blue, got.blue);
            failures++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == KIND_COLOR) begin
          expected_colors = {expected_colors, pixel_color(int'(s_tdata[ITER_W-1:0]))};
        end else begin
          count_pixel(int'(s_tdata[ITER_W-1:0]));
          counts_taken++;
        end
      end
    end
    pending = expected_colors.size();
  end

endmodule

// ===== test/histogram_range_colorizer_tb.sv =====
// Top of the histogram range colorizer testbench: clock, reset, beat and
// register stimulus, result-side stalls and the verdict.
// Depends on hrc_pkg, the colorizer RTL and histogram_range_colorizer_checker.
module histogram_range_colorizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hrc_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int ITER_CEIL  = MAX_ITERATIONS_DEF;
  // Count beats give no result, so this many quiet cycles after the last
  // result covers any count still being written.
  localparam int SETTLE = 32;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 65;
  // The phase that carries the long result stall, and how long it lasts.
  localparam int HOLD_PHASE  = 5;
  localparam int HOLD_CYCLES = 2000;
  // Slowest correct run: about 546 beats, each a full 1024-bin walk plus the
  // dividers, the longest gaps on both sides, the long stall and the clearing
  // sweep after reset. The limit leaves several times that.
  localparam int LIMIT = 3_000_000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  s_tuser   = KIND_COUNT;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BOUND_0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int failures, pending, counts_taken, colors_checked;
  int cycle_count = 0;
  int settings_loaded = 0;

  // Shared between the stimulus and the result-side process: fast_mode turns
  // off idling on both sides, long_hold_req asks for one long result stall.
  bit fast_mode = 1'b0;
  bit long_hold_req = 1'b0;
  // Bounds as last written, used only to aim counts at range edges.
  logic [BOUND_W-1:0] cur_bounds [NUM_BOUNDS];

  always #(CLK_PERIOD / 2) clk = ~clk;

  histogram_range_colorizer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  histogram_range_colorizer_checker color_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .failures       (failures),
    .pending        (pending),
    .counts_taken   (counts_taken),
    .colors_checked (colors_checked)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Timeout after %0d cycles with %0d color results outstanding.",
               cycle_count, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offers one beat and returns at the falling edge after it was taken, with
  // s_tvalid still high. The next call either keeps it high (no gap) or
  // lowers it once, so no step ever sees two assignments to it.
  task automatic send_pixel(input logic kind, input int it);
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= IN_DATA_W'(it);
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Stops offering beats until every color asked for has come back, then lets
  // any count beat still in flight finish before the registers change.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // Writes all eight registers back to back; only called while idle.
  task automatic load_palette(input logic [BOUND_W-1:0] b0, b1, b2, b3,
                              input logic [COLOR_W-1:0] c0, c1, c2, c3);
    write_reg(CFG_BOUND_0, CFG_DATA_W'(b0));
    write_reg(CFG_BOUND_1, CFG_DATA_W'(b1));
    write_reg(CFG_BOUND_2, CFG_DATA_W'(b2));
    write_reg(CFG_BOUND_3, CFG_DATA_W'(b3));
    write_reg(CFG_COLOR_0, c0);
    write_reg(CFG_COLOR_1, c1);
    write_reg(CFG_COLOR_2, c2);
    write_reg(CFG_COLOR_3, c3);
    cfg_we <= 1'b0;
    cur_bounds[0] = b0;
    cur_bounds[1] = b1;
    cur_bounds[2] = b2;
    cur_bounds[3] = b3;
    settings_loaded++;
  endtask

  // Iteration counts: a few at the maximum (inside the set), a share packed
  // around the current range bounds where the walk starts and ends, the rest
  // spread over the whole histogram.
  function automatic int pick_iterations();
    int sel, it;
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      return ITER_CEIL;
    end
    if (sel < 20) begin
      it = int'(cur_bounds[$urandom_range(0, NUM_BOUNDS - 1)]) + $urandom_range(0, 4) - 2;
      if (it < 0) begin
        it = 0;
      end
      if (it > ITER_CEIL - 1) begin
        it = ITER_CEIL - 1;
      end
      return it;
    end
    return $urandom_range(0, ITER_CEIL - 1);
  endfunction

  // Result side: a random stall before each beat, none in fast phases, and
  // once a long stall so that finished colors back up into the input.
  initial begin : receiver
    int gap;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = fast_mode ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [BOUND_W-1:0] b [NUM_BOUNDS];
    logic [BOUND_W-1:0] swap;
    logic [COLOR_W-1:0] c [NUM_BOUNDS];
    logic kind;
    for (int i = 0; i < NUM_BOUNDS; i++) begin
      cur_bounds[i] = BOUND_RST[i];
    end
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, on the reset palette. The block is still clearing its
    // bins, so the first beat also waits out the sweep.
    // A color request before any count: the range total is zero, so the
    // answer is the start color of range one.
    send_pixel(KIND_COLOR, 500);
    // Counts at both ends of every range, at the maximum (ignored) and
    // repeated in a few bins.
    send_pixel(KIND_COUNT, 0);
    send_pixel(KIND_COUNT, 306);
    send_pixel(KIND_COUNT, 307);
    send_pixel(KIND_COUNT, 511);
    send_pixel(KIND_COUNT, 512);
    send_pixel(KIND_COUNT, 1023);
    send_pixel(KIND_COUNT, ITER_CEIL);
    send_pixel(KIND_COUNT, 0);
    send_pixel(KIND_COUNT, 1023);
    send_pixel(KIND_COUNT, 200);
    // Colors at the range edges, inside the set (black) and in between.
    send_pixel(KIND_COLOR, 0);
    send_pixel(KIND_COLOR, 306);
    send_pixel(KIND_COLOR, 307);
    send_pixel(KIND_COLOR, 511);
    send_pixel(KIND_COLOR, 512);
    send_pixel(KIND_COLOR, 1023);
    send_pixel(KIND_COLOR, ITER_CEIL);
    send_pixel(KIND_COLOR, 100);
    send_pixel(KIND_COLOR, 400);

    // Random phases. The histogram carries over from phase to phase, so once
    // the bounds move a walk can cover more pixels than its range total and
    // the channel has to clamp.
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        c[i] = COLOR_W'($urandom());
      end
      case (p)
        // One range over everything, black to white: the longest walks.
        0: load_palette(11'd0, 11'd1024, 11'd1024, 11'd1024,
                        24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF);
        // Every bound at the top: each walk starts above its count.
        1: load_palette(11'd1024, 11'd1024, 11'd1024, 11'd1024,
                        24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000);
        // Bounds out of order.
        2: load_palette(11'd600, 11'd200, 11'd900, 11'd100, c[0], c[1], c[2], c[3]);
        // Every bound at zero: no bound lies above a count, so the last range
        // takes them all.
        3: load_palette(11'd0, 11'd0, 11'd0, 11'd0, c[0], c[1], c[2], c[3]);
        // Falling colors give negative steps that floor downward; counts from
        // 1000 up lie past the last bound.
        4: load_palette(11'd100, 11'd400, 11'd700, 11'd1000,
                        24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000);
        // Reset bounds with random colors; carries the long stall.
        HOLD_PHASE: load_palette(11'd0, 11'd307, 11'd512, 11'd1024,
                                 c[0], c[1], c[2], c[3]);
        default: begin
          for (int i = 0; i < NUM_BOUNDS; i++) begin
            b[i] = BOUND_W'($urandom_range(0, ITER_CEIL));
          end
          for (int i = 0; i < NUM_BOUNDS - 1; i++) begin
            for (int j = 0; j < NUM_BOUNDS - 1 - i; j++) begin
              if (b[j] > b[j+1]) begin
                swap = b[j];
                b[j] = b[j+1];
                b[j+1] = swap;
              end
            end
          end
          load_palette(b[0], b[1], b[2], b[3], c[0], c[1], c[2], c[3]);
        end
      endcase
      fast_mode = (p % 3 == 1);

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == HOLD_PHASE && k == 20) begin
          // Short-walk colors sent back to back while the result side stalls:
          // one waits in the output register, the next finishes behind it and
          // the input has to stop.
          long_hold_req = 1'b1;
          fast_mode = 1'b1;
          for (int n = 0; n < 6; n++) begin
            send_pixel(KIND_COLOR, $urandom_range(0, 40));
          end
          fast_mode = 1'b0;
        end
        kind = ($urandom_range(0, 99) < 40) ? KIND_COLOR : KIND_COUNT;
        send_pixel(kind, pick_iterations());
      end
    end

    drain_results();
    $display("Covered %0d count beats and %0d color beats over %0d register settings,",
             counts_taken, colors_checked, settings_loaded + 1);
    $display("with extreme and out-of-order bounds and a long stall on the result side.");
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== histogram_range_colorizer.f =====
+incdir+rtl/core
rtl/core/hrc_pkg.sv
rtl/core/hrc_ram.sv
rtl/core/hrc_ctrl.sv
rtl/core/hrc_datapath.sv
rtl/core/histogram_range_colorizer.sv
test/histogram_range_colorizer_checker.sv
test/histogram_range_colorizer_tb.sv
